@@ rtl/core/hwt_pkg.sv @@
// Shared constants, types and time arithmetic for the hashed timer wheel.
`timescale 1ns / 1ps
`default_nettype none
package hwt_pkg;

   // The wheel size is a power of two, given by its number of index bits.
   localparam int WHEEL_SLOT_BITS = 6;
   localparam int WHEEL_SLOTS = 1 << WHEEL_SLOT_BITS;
   localparam int TIMER_ENTRIES = 16;
   localparam int ENTRY_W = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
   localparam int ECNT_W = $clog2(TIMER_ENTRIES + 1);

   localparam int FUNC_W = 2;
   localparam int ID_W = 4;
   localparam int PERIOD_W = 20;
   localparam int ROUND_W = 32;
   localparam int SUM_W = PERIOD_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REG = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEREG = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] interval;
      logic                periodic;
   } item_type;

   typedef struct packed {
      logic [WHEEL_SLOT_BITS-1:0] slot;
      logic [ROUND_W-1:0]         round;
   } wheel_pos_type;

   typedef struct packed {
      logic [WHEEL_SLOT_BITS-1:0] slot;
      logic [ROUND_W-1:0]         round;
      logic [PERIOD_W-1:0]        period;
      logic                       periodic;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic pend_valid;
   } back_status_type;

   // Wheel position of now + period, where a zero period counts as one tick.
   function automatic wheel_pos_type arm_time(
      input logic [WHEEL_SLOT_BITS-1:0] ptr,
      input logic [ROUND_W-1:0]         rnd,
      input logic [PERIOD_W-1:0]        period
   );
      logic [PERIOD_W-1:0] p;
      logic [SUM_W-1:0]    sum;
      wheel_pos_type       pos;
      p = (period == '0) ? PERIOD_W'(1) : period;
      sum = SUM_W'(ptr) + SUM_W'(p);
      pos.slot = sum[WHEEL_SLOT_BITS-1:0];
      pos.round = rnd + ROUND_W'(sum >> WHEEL_SLOT_BITS);
      return pos;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/hashed_timer_wheel.sv @@
// Top level of the hashed timer wheel: request queue, timer engine and checks.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   func, timer_id, interval, periodic
//   rsp_      out        rsp_valid/rsp_ready   expired_id, rearmed, last_expiry
//
// Register and deregister transactions are handled by the engine straight from idle, without a scan.
// During a tick the scan reads one entry per cycle while it is not stalled, through
// the single read port of the entry table.
// A two-deep queue keeps accepting requests while the engine scans, until it is full.
// A stalled result channel holds the scan only when a second expiry is waiting, and
// holds the end of the tick until the result register can take its last expiry.
// Reset clears the wheel position and the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module hashed_timer_wheel (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [hwt_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [hwt_pkg::ID_W-1:0]       req_timer_id,
   input  wire logic [hwt_pkg::PERIOD_W-1:0]   req_interval,
   input  wire logic                           req_periodic,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [hwt_pkg::ID_W-1:0]            rsp_expired_id,
   output logic                                rsp_rearmed,
   output logic                                rsp_last_expiry
);

   logic                       q_valid;
   hwt_pkg::item_type          q_item;
   logic                       q_pop;
   hwt_pkg::back_status_type   status;

   hwt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_timer_id (req_timer_id),
      .req_interval (req_interval),
      .req_periodic (req_periodic),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   hwt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_expired_id  (rsp_expired_id),
      .rsp_rearmed     (rsp_rearmed),
      .rsp_last_expiry (rsp_last_expiry),
      .status          (status)
   );

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      !status.busy |-> !status.pend_valid)
      else $error("engine idle with an expiry still pending");

   a_full_queue_visible: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("request side stalled while the queue is empty");

   a_scan_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(status.busy) |-> $past(q_valid && (q_item.func == hwt_pkg::FUNC_TICK)))
      else $error("scan started without a queued tick");

endmodule
`default_nettype wire

@@ rtl/core/hwt_front.sv @@
// Request intake: classifies requests, drops void ones and queues the rest.
`timescale 1ns / 1ps
`default_nettype none
module hwt_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [hwt_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [hwt_pkg::ID_W-1:0]       req_timer_id,
   input  wire logic [hwt_pkg::PERIOD_W-1:0]   req_interval,
   input  wire logic                           req_periodic,
   output logic                                q_valid,
   output hwt_pkg::item_type                   q_item,
   input  wire logic                           q_pop
);

   hwt_pkg::item_type             q_mem_ff [hwt_pkg::QUEUE_DEPTH];
   logic [hwt_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [hwt_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [hwt_pkg::QPTR_W:0]      count_ff, count_in;
   logic                          accept;
   logic                          keep;
   logic                          push;
   logic                          pop;
   logic                          id_in_range;
   hwt_pkg::item_type             new_item;

   assign req_ready = (count_ff != (hwt_pkg::QPTR_W + 1)'(hwt_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item = q_mem_ff[rd_ptr_ff];

   assign accept = req_valid && req_ready;
   assign id_in_range = (33'(req_timer_id) < 33'(hwt_pkg::TIMER_ENTRIES));
   assign keep = (req_func == hwt_pkg::FUNC_TICK)
              || (((req_func == hwt_pkg::FUNC_REG) || (req_func == hwt_pkg::FUNC_DEREG))
                  && id_in_range);
   assign push = accept && keep;
   assign pop = q_pop && q_valid;

   assign new_item.func = req_func;
   assign new_item.id = req_timer_id;
   assign new_item.interval = req_interval;
   assign new_item.periodic = req_periodic;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = hwt_pkg::QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = hwt_pkg::QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/hwt_back.sv @@
// Timer engine: wheel position, entry table, expiry scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module hwt_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire hwt_pkg::item_type           q_item,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [hwt_pkg::ID_W-1:0]         rsp_expired_id,
   output logic                             rsp_rearmed,
   output logic                             rsp_last_expiry,
   output hwt_pkg::back_status_type         status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]                             state_ff, state_in;
   logic [hwt_pkg::WHEEL_SLOT_BITS-1:0]    ptr_ff, ptr_in;
   logic [hwt_pkg::ROUND_W-1:0]            round_ff, round_in;
   logic [hwt_pkg::TIMER_ENTRIES-1:0]      valid_ff, valid_in;
   hwt_pkg::entry_type                     ent_mem [hwt_pkg::TIMER_ENTRIES];
   hwt_pkg::entry_type                     rd_ff;
   logic                                   chk_valid_ff, chk_valid_in;
   logic [hwt_pkg::ENTRY_W-1:0]            chk_idx_ff, chk_idx_in;
   logic [hwt_pkg::ECNT_W-1:0]             scan_cnt_ff, scan_cnt_in;
   logic                                   pend_valid_ff, pend_valid_in;
   logic [hwt_pkg::ENTRY_W-1:0]            pend_id_ff, pend_id_in;
   logic                                   pend_rearm_ff, pend_rearm_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [hwt_pkg::ID_W-1:0]               rsp_id_ff, rsp_id_in;
   logic                                   rsp_rearm_ff, rsp_rearm_in;
   logic                                   rsp_last_ff, rsp_last_in;

   logic                                   can_push;
   logic                                   hit;
   logic                                   stall;
   logic                                   issue;
   logic                                   scan_done;
   logic                                   push;
   logic [hwt_pkg::ENTRY_W-1:0]            push_id;
   logic                                   push_rearm;
   logic                                   push_last;
   logic                                   mem_we;
   logic [hwt_pkg::ENTRY_W-1:0]            mem_wa;
   hwt_pkg::entry_type                     mem_wd;
   hwt_pkg::wheel_pos_type                 reg_pos;
   hwt_pkg::wheel_pos_type                 rearm_pos;
   logic [hwt_pkg::ENTRY_W-1:0]            item_idx;

   assign can_push = !rsp_valid_ff || rsp_ready;
   assign q_pop = (state_ff == ST_IDLE);
   assign hit = chk_valid_ff && valid_ff[chk_idx_ff]
             && (rd_ff.slot == ptr_ff) && (rd_ff.round == round_ff);
   assign stall = hit && pend_valid_ff && !can_push;
   assign scan_done = (scan_cnt_ff == hwt_pkg::ECNT_W'(hwt_pkg::TIMER_ENTRIES));
   assign issue = (state_ff == ST_SCAN) && !stall && !scan_done;
   assign reg_pos = hwt_pkg::arm_time(ptr_ff, round_ff, q_item.interval);
   assign rearm_pos = hwt_pkg::arm_time(ptr_ff, round_ff, rd_ff.period);
   assign item_idx = hwt_pkg::ENTRY_W'(q_item.id);

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      round_in = round_ff;
      valid_in = valid_ff;
      chk_valid_in = chk_valid_ff;
      chk_idx_in = chk_idx_ff;
      scan_cnt_in = scan_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in = pend_id_ff;
      pend_rearm_in = pend_rearm_ff;
      push = 1'b0;
      push_id = pend_id_ff;
      push_rearm = pend_rearm_ff;
      push_last = 1'b0;
      mem_we = 1'b0;
      mem_wa = item_idx;
      mem_wd.slot = reg_pos.slot;
      mem_wd.round = reg_pos.round;
      mem_wd.period = q_item.interval;
      mem_wd.periodic = q_item.periodic;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_item.func)
                  hwt_pkg::FUNC_REG: begin
                     mem_we = 1'b1;
                     valid_in[item_idx] = 1'b1;
                  end
                  hwt_pkg::FUNC_DEREG: begin
                     valid_in[item_idx] = 1'b0;
                  end
                  hwt_pkg::FUNC_TICK: begin
                     if (ptr_ff == hwt_pkg::WHEEL_SLOT_BITS'(hwt_pkg::WHEEL_SLOTS - 1)) begin
                        ptr_in = '0;
                        round_in = round_ff + 1'b1;
                     end else begin
                        ptr_in = ptr_ff + 1'b1;
                     end
                     scan_cnt_in = '0;
                     chk_valid_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               chk_valid_in = issue;
               if (issue) begin
                  chk_idx_in = scan_cnt_ff[hwt_pkg::ENTRY_W-1:0];
                  scan_cnt_in = scan_cnt_ff + 1'b1;
               end
               if (hit) begin
                  if (rd_ff.periodic) begin
                     mem_we = 1'b1;
                     mem_wa = chk_idx_ff;
                     mem_wd.slot = rearm_pos.slot;
                     mem_wd.round = rearm_pos.round;
                     mem_wd.period = rd_ff.period;
                     mem_wd.periodic = 1'b1;
                  end else begin
                     valid_in[chk_idx_ff] = 1'b0;
                  end
                  push = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_id_in = chk_idx_ff;
                  pend_rearm_in = rd_ff.periodic;
               end
               if (!chk_valid_ff && scan_done) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (can_push) begin
               push = 1'b1;
               push_last = 1'b1;
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in = rsp_id_ff;
      rsp_rearm_in = rsp_rearm_ff;
      rsp_last_in = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_id_in = hwt_pkg::ID_W'(push_id);
         rsp_rearm_in = push_rearm;
         rsp_last_in = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff <= '0;
         round_ff <= '0;
         valid_ff <= '0;
         chk_valid_ff <= 1'b0;
         scan_cnt_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         round_ff <= round_in;
         valid_ff <= valid_in;
         chk_valid_ff <= chk_valid_in;
         scan_cnt_ff <= scan_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      pend_id_ff <= pend_id_in;
      pend_rearm_ff <= pend_rearm_in;
      rsp_id_ff <= rsp_id_in;
      rsp_rearm_ff <= rsp_rearm_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ent_mem[mem_wa] <= mem_wd;
      end
      if (issue) begin
         rd_ff <= ent_mem[scan_cnt_ff[hwt_pkg::ENTRY_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_rearmed = rsp_rearm_ff;
   assign rsp_last_expiry = rsp_last_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.pend_valid = pend_valid_ff;

endmodule
`default_nettype wire
